// ----- rtl/mhml_pkg.sv -----
// Shared types and constants for the multiplicative hash / mod-length core.
// No dependencies; imported by every module of the block.
`default_nettype none

package mhml_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 32;
    localparam int CNT_W  = 16;
    localparam int REM_W  = CNT_W;
    localparam int STEP_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(37);
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_W - 1);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIV,
        ST_LOAD
    } mhml_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/mhml_accum.sv -----
// Running hash (hash * 37 + byte, mod 2^32) and saturating byte counter.
// Depends on mhml_pkg.
`default_nettype none

module mhml_accum (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       beat,
    input  wire logic                       last_byte,
    input  wire logic [mhml_pkg::BYTE_W-1:0] byte_value,
    output logic      [mhml_pkg::HASH_W-1:0] hash_upd,
    output logic      [mhml_pkg::CNT_W-1:0]  count_upd,
    output logic                             ovf_upd
);
    import mhml_pkg::*;

    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              at_max;

    // constant multiply; synthesis folds it into shift-adds
    assign hash_upd  = hash_reg * HASH_MULT + HASH_W'(byte_value);
    assign at_max    = (count_reg == COUNT_MAX);
    assign count_upd = at_max ? count_reg : count_reg + CNT_W'(1);
    assign ovf_upd   = ovf_reg | at_max;

    always_comb
    begin
        hash_next  = hash_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (beat)
        begin
            if (last_byte)
            begin
                hash_next  = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                hash_next  = hash_upd;
                count_next = count_upd;
                ovf_next   = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mhml_div.sv -----
// Restoring remainder unit: one dividend bit per cycle through a shared
// 17-bit subtractor. Depends on mhml_pkg.
`default_nettype none

module mhml_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mhml_pkg::div_ctrl_t        ctrl,
    input  wire logic [mhml_pkg::HASH_W-1:0] dividend,
    input  wire logic [mhml_pkg::CNT_W-1:0]  divisor,
    output mhml_pkg::div_stat_t             stat,
    output logic      [mhml_pkg::REM_W-1:0]  remainder
);
    import mhml_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic [REM_W-1:0]  rem_step;

    // partial remainder stays below the divisor, so trial < 2 * divisor
    assign trial    = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_step = diff[REM_W] ? trial[REM_W-1:0] : diff[REM_W-1:0];

    assign stat.done = busy_reg && (step_reg == STEP_LAST);
    assign remainder = rem_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (ctrl.start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = rem_step;
            dvd_next  = {dvd_reg[HASH_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            busy_next = (step_reg != STEP_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ----- rtl/multiplicative_hash_mod_length_core.sv -----
// Top level: byte stream in, one hash-mod-length result per message out.
// Depends on mhml_pkg, mhml_accum, mhml_div.
//
// Usage:
//   Input stream (s_*): one message byte per beat in s_tdata, s_tlast on the
//   final byte. Non-final bytes are taken one per cycle; each updates a
//   32-bit running hash (hash * 37 + byte) and a byte count that saturates
//   at 65535 (a byte past that marks the message as too long).
//   Output stream (m_*): one beat per message. m_tdata holds the hash modulo
//   the byte count; m_tuser is the too-long flag (remainder then zero).
//   Result path: the final byte starts a restoring remainder unit that handles
//   one dividend bit per cycle over the 32-bit hash, then the result is loaded
//   into the output register. A too-long message skips the unit and goes
//   straight to the output register. s_tready is low from the final byte
//   until the result enters the output register.
//   Stall: the output register holds the result while m_tready is low. The
//   next message's bytes keep flowing meanwhile and its final byte is taken;
//   once its result is ready it waits for the output slot with s_tready low.
//   Reset (rst_n low, asynchronous) clears hash, count, flags and m_tvalid.
`default_nettype none

module multiplicative_hash_mod_length_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // slave stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [mhml_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_value
    input  wire logic                       s_tlast,   // last_byte
    // master stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [mhml_pkg::REM_W-1:0]  m_tdata,   // [15:0] hash_remainder
    output logic                            m_tuser    // [0] too_long
);
    import mhml_pkg::*;

    mhml_state_t       state_reg, state_next;

    logic              beat;
    logic              last_beat;
    logic              out_free;
    logic              load_out;

    logic [HASH_W-1:0] hash_upd;
    logic [CNT_W-1:0]  count_upd;
    logic              ovf_upd;

    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;
    logic [REM_W-1:0]  div_rem;

    logic              long_pend_reg, long_pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [REM_W-1:0]  m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    assign beat      = s_tvalid && s_tready;
    assign last_beat = beat && s_tlast;
    assign out_free  = !m_valid_reg || m_tready;

    mhml_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .last_byte  (s_tlast),
        .byte_value (s_tdata),
        .hash_upd   (hash_upd),
        .count_upd  (count_upd),
        .ovf_upd    (ovf_upd)
    );

    mhml_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (hash_upd),
        .divisor   (count_upd),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (last_beat)
                begin
                    state_next = ovf_upd ? ST_LOAD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready       = 1'b0;
        load_out       = 1'b0;
        div_ctrl.start = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready       = 1'b1;
                div_ctrl.start = s_tvalid && s_tlast && !ovf_upd;
            end
            ST_DIV:
            begin
                s_tready = 1'b0;
            end
            ST_LOAD:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // too-long flag held across the divide / load wait
    assign long_pend_next = last_beat ? ovf_upd : long_pend_reg;

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = long_pend_reg ? '0 : div_rem;
            m_user_next  = long_pend_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            long_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            long_pend_reg <= long_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- rtl/mhml_checker.sv -----
// Port-level checks for multiplicative_hash_mod_length_core, bound to it.
// Depends on mhml_pkg.
`default_nettype none

module mhml_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      s_tlast,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [mhml_pkg::REM_W-1:0] m_tdata,
    input wire logic                      m_tuser
);
    import mhml_pkg::*;

    // a final byte always stops intake in the cycle after it
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input ready after final byte");

    // a new result only appears out of a cycle with intake stopped
    a_result_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while taking bytes");

    // too-long results carry a zero remainder
    a_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("too-long result with nonzero remainder");

    // remainder is below the divisor, which never exceeds the count ceiling
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata != COUNT_MAX)
        else $error("remainder out of range");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind multiplicative_hash_mod_length_core mhml_checker u_mhml_checker (.*);

`default_nettype wire

// ----- test/multiplicative_hash_mod_length_core_test.sv -----
// Self-checking testbench for multiplicative_hash_mod_length_core: streams messages, predicts
// each hash-mod-length beat and compares it with the output stream. Depends on mhml_pkg.
`timescale 1ns / 1ps

module multiplicative_hash_mod_length_core_test;

    import mhml_pkg::*;

    localparam logic [31:0] HASH_FACTOR = 32'd37;
    localparam logic [15:0] LEN_LIMIT   = 16'hFFFF;
    localparam int          IDLE_PCT    = 37;
    localparam int          HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int          QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int          DRAIN_WAIT  = 40;    // divider latency plus margin
    localparam int          RAND_BEATS  = 1600;
    localparam int          RAND_MSGS   = 60;

    typedef struct packed {
        logic [REM_W-1:0] hash_remainder;
        logic             too_long;
    } digest_t;

    // One directed row: `lead` non-final copies of the byte, then the byte with last_byte.
    typedef struct {
        logic [7:0]  byte_value;
        int unsigned lead;
        logic        last_byte;
        bit          typed;
        digest_t     digest;
    } stim_row_t;

    localparam int ROWS = 18;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [REM_W-1:0] m_tdata;
    logic             m_tuser;

    // predictor state
    logic [31:0] hash_acc     = '0;
    logic [15:0] len_count    = '0;
    logic        len_overflow = 1'b0;

    digest_t     pending_digests[$];
    int          error_count   = 0;
    int          beats_sent    = 0;
    int          digests_seen  = 0;
    int          overlong_seen = 0;
    bit          tx_calm       = 1'b0;
    bit          rx_calm       = 1'b0;
    bit          pressure_go   = 1'b0;

    stim_row_t   rows[ROWS];

    multiplicative_hash_mod_length_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the hash on one accepted byte; returns 1 with the digest on a final byte.
    function automatic bit digest_step(input logic [7:0] b, input logic fin,
                                       output digest_t res);
        logic [31:0] rem32;
        hash_acc = hash_acc * HASH_FACTOR + {24'd0, b};
        if (len_count == LEN_LIMIT)
            len_overflow = 1'b1;
        else
            len_count = len_count + 16'd1;
        res = '0;
        if (!fin)
            return 1'b0;
        if (len_overflow)
        begin
            res.too_long = 1'b1;
        end
        else
        begin
            rem32 = hash_acc % {16'd0, len_count};
            res.hash_remainder = rem32[15:0];
        end
        hash_acc     = '0;
        len_count    = '0;
        len_overflow = 1'b0;
        return 1'b1;
    endfunction

    // Offer one byte with random idle gaps; on acceptance predict and queue the digest.
    task automatic push_byte(input logic [7:0] b, input logic fin,
                             input bit typed, input digest_t typed_res);
        digest_t res;
        while (!tx_calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        if (digest_step(b, fin, res))
            pending_digests.push_back(typed ? typed_res : res);
    endtask

    // Receiver: random m_tready, a calm stretch, and one long hold-off on request.
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result check: every output beat against the oldest queued digest.
    always @(posedge clk)
    begin
        digest_t exp_d;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (pending_digests.size() == 0)
            begin
                $error("result beat with nothing expected: hash_remainder=%0d too_long=%0d",
                       m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                exp_d = pending_digests.pop_front();
                digests_seen++;
                if (m_tuser)
                    overlong_seen++;
                if (m_tdata !== exp_d.hash_remainder)
                begin
                    $error("hash_remainder: expected %0d, actual %0d",
                           exp_d.hash_remainder, m_tdata);
                    error_count++;
                end
                if (m_tuser !== exp_d.too_long)
                begin
                    $error("too_long: expected %0d, actual %0d", exp_d.too_long, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: give up when neither side moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat for %0d cycles, %0d digests outstanding",
                 QUIET_LIMIT, pending_digests.size());
        $display("multiplicative_hash_mod_length_core_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int          msgs;
        int          rand_beats;
        int          len;
        int          pick;
        digest_t     no_digest;
        stim_row_t   r;

        no_digest = '0;
        // single bytes right after reset: remainder of anything mod 1
        rows[0]  = '{8'h00, 0,     1'b1, 1'b1, '{16'd0, 1'b0}};
        rows[1]  = '{8'hFF, 0,     1'b1, 1'b1, '{16'd0, 1'b0}};
        rows[2]  = '{8'hFF, 1,     1'b1, 1'b0, '0};
        rows[3]  = '{8'h01, 0,     1'b0, 1'b0, '0};
        rows[4]  = '{8'h02, 0,     1'b0, 1'b0, '0};
        rows[5]  = '{8'h03, 0,     1'b1, 1'b0, '0};
        rows[6]  = '{8'h80, 6,     1'b1, 1'b0, '0};
        // long enough that the 32-bit hash wraps many times
        rows[7]  = '{8'h7F, 30,    1'b1, 1'b0, '0};
        rows[8]  = '{8'hFF, 65533, 1'b1, 1'b0, '0};
        // exactly 65535 bytes: count at its ceiling, still not too long
        rows[9]  = '{8'hFF, 65534, 1'b1, 1'b0, '0};
        rows[10] = '{8'h00, 0,     1'b1, 1'b1, '{16'd0, 1'b0}};
        // one byte past the ceiling: flagged, remainder forced to zero
        rows[11] = '{8'h5A, 65535, 1'b1, 1'b1, '{16'd0, 1'b1}};
        // state must be clean after an overlong message
        rows[12] = '{8'hFF, 0,     1'b1, 1'b1, '{16'd0, 1'b0}};
        rows[13] = '{8'hA5, 65600, 1'b1, 1'b1, '{16'd0, 1'b1}};
        rows[14] = '{8'h3C, 0,     1'b0, 1'b0, '0};
        rows[15] = '{8'hC3, 0,     1'b1, 1'b0, '0};
        rows[16] = '{8'h55, 2,     1'b0, 1'b0, '0};
        rows[17] = '{8'hAA, 0,     1'b1, 1'b0, '0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < ROWS; i++)
        begin
            r = rows[i];
            for (int unsigned k = 0; k < r.lead; k++)
                push_byte(r.byte_value, 1'b0, 1'b0, no_digest);
            push_byte(r.byte_value, r.last_byte, r.typed, r.digest);
        end

        // back-pressure: receiver holds off while short messages keep coming
        tx_calm     = 1'b1;
        pressure_go = 1'b1;
        for (int m = 0; m < 20; m++)
        begin
            len = $urandom_range(3, 1);
            for (int k = 0; k < len; k++)
                push_byte(8'($urandom_range(255)), k == len - 1, 1'b0, no_digest);
        end
        tx_calm = 1'b0;

        // random messages, mostly short, a few long ones
        msgs       = 0;
        rand_beats = 0;
        while (rand_beats < RAND_BEATS || msgs < RAND_MSGS)
        begin
            tx_calm = (msgs >= 30 && msgs < 45);
            rx_calm = tx_calm;
            pick = $urandom_range(99);
            if (pick < 60)
                len = $urandom_range(4, 1);
            else if (pick < 95)
                len = $urandom_range(64, 5);
            else
                len = $urandom_range(600, 200);
            for (int k = 0; k < len; k++)
                push_byte(8'($urandom_range(255)), k == len - 1, 1'b0, no_digest);
            rand_beats += len;
            msgs++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_digests.size() != 0)
        begin
            $error("%0d digests never arrived", pending_digests.size());
            error_count++;
        end

        $display("covered %0d input beats and %0d checked digests (%0d flagged too long),",
                 beats_sent, digests_seen, overlong_seen);
        $display("from single bytes up to past the 65535-byte ceiling, with output hold-off");
        if (error_count == 0)
            $display("multiplicative_hash_mod_length_core_test: PASS");
        else
            $display("multiplicative_hash_mod_length_core_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mhml_pkg.sv
rtl/mhml_accum.sv
rtl/mhml_div.sv
rtl/multiplicative_hash_mod_length_core.sv
rtl/mhml_checker.sv
test/multiplicative_hash_mod_length_core_test.sv
